// File: sv/qnorm_pkg.sv
// Shared types and widths for the quaternion normalize unit.
// Used by every module of the block; depends on nothing else.
`default_nettype none

package qnorm_pkg;

   // Lane count: x, y, z, w
   localparam int LANES    = 4;
   localparam int COMP_W   = 16;
   localparam int MAG_W    = 16;
   // Square of a magnitude is at most 2^30
   localparam int SQ_W     = 31;
   // Sum of four squares is at most 2^32
   localparam int SUM_W    = 33;
   // floor(2^30 * m^2 / S) is at most 2^30
   localparam int QUO_W    = 31;
   // Divider partial remainder, shifted, stays below 2^33
   localparam int REM_W    = 34;
   // Integer square root of the quotient is at most 2^15
   localparam int ROOT_W   = 16;
   localparam int RAD_W    = 2 * ROOT_W;
   localparam int SREM_W   = ROOT_W + 4;
   localparam int UNIT_W   = 16;

   // Lane indexes
   localparam int LANE_X   = 0;
   localparam int LANE_Y   = 1;
   localparam int LANE_Z   = 2;
   localparam int LANE_W   = 3;

   typedef logic signed [COMP_W-1:0] comp_type;
   typedef logic [MAG_W-1:0]         mag_type;
   typedef logic [SQ_W-1:0]          sq_type;
   typedef logic [SUM_W-1:0]         sum_type;
   typedef logic [QUO_W-1:0]         quo_type;
   typedef logic [REM_W-1:0]         rem_type;
   typedef logic [ROOT_W-1:0]        root_type;
   typedef logic [RAD_W-1:0]         rad_type;
   typedef logic [SREM_W-1:0]        srem_type;
   typedef logic signed [UNIT_W-1:0] unit_type;

   // Q1.14 one
   localparam unit_type UNIT_ONE = unit_type'(16384);

   // Sideband that travels with each transaction
   typedef struct packed {
      logic [LANES-1:0] neg;
      logic             zero;
   } side_type;

endpackage

`default_nettype wire

// File: sv/qnorm_sumsq.sv
// Front end: component magnitudes, squares and the sum of squares.
// Two register stages; depends on qnorm_pkg.
`default_nettype none

module qnorm_sumsq (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               enable,
   input  wire logic               in_valid,
   input  wire qnorm_pkg::comp_type comp [qnorm_pkg::LANES],
   output logic                    out_valid,
   output qnorm_pkg::sq_type       sq [qnorm_pkg::LANES],
   output qnorm_pkg::sum_type      sum,
   output qnorm_pkg::side_type     side
);
   import qnorm_pkg::*;

   logic [LANES-1:0]     neg_in;
   mag_type              mag_in [LANES];
   logic [2*MAG_W-1:0]   prod_in [LANES];
   sq_type               sq1_in [LANES];

   logic                 valid1_ff;
   logic [LANES-1:0]     neg1_ff;
   sq_type               sq1_ff [LANES];

   sum_type              sum2_in;
   side_type             side2_in;
   logic                 valid2_ff;
   sq_type               sq2_ff [LANES];
   sum_type              sum2_ff;
   side_type             side2_ff;

   // Take magnitudes and square them
   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         neg_in[l]  = comp[l][COMP_W-1];
         mag_in[l]  = neg_in[l] ? mag_type'(-comp[l]) : mag_type'(comp[l]);
         prod_in[l] = mag_in[l] * mag_in[l];
         sq1_in[l]  = prod_in[l][SQ_W-1:0];
      end
   end

   // Add the four squares, flag a zero length
   always_comb begin
      sum2_in = '0;
      for (int l = 0; l < LANES; l++) begin
         sum2_in = sum2_in + sum_type'(sq1_ff[l]);
      end
      side2_in.neg  = neg1_ff;
      side2_in.zero = (sum2_in == '0);
   end

   // Advance valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         valid1_ff <= 1'b0;
         valid2_ff <= 1'b0;
      end else if (enable) begin
         valid1_ff <= in_valid;
         valid2_ff <= valid1_ff;
      end
   end

   // Advance payload
   always_ff @(posedge clock) begin
      if (enable) begin
         neg1_ff  <= neg_in;
         sq1_ff   <= sq1_in;
         sq2_ff   <= sq1_ff;
         sum2_ff  <= sum2_in;
         side2_ff <= side2_in;
      end
   end

   assign out_valid = valid2_ff;
   assign sq        = sq2_ff;
   assign sum       = sum2_ff;
   assign side      = side2_ff;

endmodule

`default_nettype wire

// File: sv/qnorm_div.sv
// Pipelined restoring divider: floor(2^30 * m^2 / S) for each lane,
// one quotient bit per stage. Depends on qnorm_pkg.
`default_nettype none

module qnorm_div (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               enable,
   input  wire logic               in_valid,
   input  wire qnorm_pkg::sq_type  sq [qnorm_pkg::LANES],
   input  wire qnorm_pkg::sum_type sum,
   input  wire qnorm_pkg::side_type in_side,
   output logic                    out_valid,
   output qnorm_pkg::quo_type      quo [qnorm_pkg::LANES],
   output qnorm_pkg::side_type     out_side
);
   import qnorm_pkg::*;

   // Stage registers; remainder and divisor are not kept past the last bit
   logic [QUO_W-1:0] valid_ff;
   side_type         side_ff [QUO_W];
   quo_type          quo_ff  [QUO_W][LANES];
   rem_type          rem_ff  [QUO_W-1][LANES];
   sum_type          div_ff  [QUO_W-1];

   // Per-stage operands
   rem_type          rem_sh  [QUO_W][LANES];
   quo_type          quo_src [QUO_W][LANES];
   sum_type          div_src [QUO_W];
   side_type         side_src[QUO_W];
   logic [QUO_W-1:0] valid_src;
   rem_type          rem_in  [QUO_W][LANES];
   quo_type          quo_in  [QUO_W][LANES];

   for (genvar g = 0; g < QUO_W; g++) begin : g_step
      // Select operands: the first stage takes m^2 as is (integer bit)
      if (g == 0) begin : g_first
         always_comb begin
            for (int l = 0; l < LANES; l++) begin
               rem_sh[g][l]  = rem_type'(sq[l]);
               quo_src[g][l] = '0;
            end
            div_src[g]   = sum;
            side_src[g]  = in_side;
            valid_src[g] = in_valid;
         end
      end else begin : g_next
         always_comb begin
            for (int l = 0; l < LANES; l++) begin
               rem_sh[g][l]  = {rem_ff[g-1][l][REM_W-2:0], 1'b0};
               quo_src[g][l] = quo_ff[g-1][l];
            end
            div_src[g]   = div_ff[g-1];
            side_src[g]  = side_ff[g-1];
            valid_src[g] = valid_ff[g-1];
         end
      end

      // Compare and subtract, shift in one quotient bit
      always_comb begin
         for (int l = 0; l < LANES; l++) begin
            if (rem_sh[g][l] >= rem_type'(div_src[g])) begin
               rem_in[g][l] = rem_sh[g][l] - rem_type'(div_src[g]);
               quo_in[g][l] = {quo_src[g][l][QUO_W-2:0], 1'b1};
            end else begin
               rem_in[g][l] = rem_sh[g][l];
               quo_in[g][l] = {quo_src[g][l][QUO_W-2:0], 1'b0};
            end
         end
      end

      // Advance valid
      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[g] <= 1'b0;
         end else if (enable) begin
            valid_ff[g] <= valid_src[g];
         end
      end

      // Advance payload
      always_ff @(posedge clock) begin
         if (enable) begin
            side_ff[g] <= side_src[g];
            quo_ff[g]  <= quo_in[g];
         end
      end

      if (g < QUO_W - 1) begin : g_keep
         always_ff @(posedge clock) begin
            if (enable) begin
               rem_ff[g] <= rem_in[g];
               div_ff[g] <= div_src[g];
            end
         end
      end
   end

   assign out_valid = valid_ff[QUO_W-1];
   assign quo       = quo_ff[QUO_W-1];
   assign out_side  = side_ff[QUO_W-1];

endmodule

`default_nettype wire

// File: sv/qnorm_sqrt.sv
// Pipelined integer square root of each lane's quotient,
// one root bit per stage. Depends on qnorm_pkg.
`default_nettype none

module qnorm_sqrt (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               enable,
   input  wire logic               in_valid,
   input  wire qnorm_pkg::quo_type quo [qnorm_pkg::LANES],
   input  wire qnorm_pkg::side_type in_side,
   output logic                    out_valid,
   output qnorm_pkg::root_type     root [qnorm_pkg::LANES],
   output qnorm_pkg::side_type     out_side
);
   import qnorm_pkg::*;

   // Stage registers; remainder and radicand are not kept past the last bit
   logic [ROOT_W-1:0] valid_ff;
   side_type          side_ff [ROOT_W];
   root_type          root_ff [ROOT_W][LANES];
   srem_type          rem_ff  [ROOT_W-1][LANES];
   rad_type           rad_ff  [ROOT_W-1][LANES];

   // Per-stage operands
   srem_type          rem_src  [ROOT_W][LANES];
   rad_type           rad_src  [ROOT_W][LANES];
   root_type          root_src [ROOT_W][LANES];
   side_type          side_src [ROOT_W];
   logic [ROOT_W-1:0] valid_src;
   srem_type          rem_in   [ROOT_W][LANES];
   rad_type           rad_in   [ROOT_W][LANES];
   root_type          root_in  [ROOT_W][LANES];

   for (genvar g = 0; g < ROOT_W; g++) begin : g_step
      if (g == 0) begin : g_first
         always_comb begin
            for (int l = 0; l < LANES; l++) begin
               rem_src[g][l]  = '0;
               rad_src[g][l]  = rad_type'(quo[l]);
               root_src[g][l] = '0;
            end
            side_src[g]  = in_side;
            valid_src[g] = in_valid;
         end
      end else begin : g_next
         always_comb begin
            for (int l = 0; l < LANES; l++) begin
               rem_src[g][l]  = rem_ff[g-1][l];
               rad_src[g][l]  = rad_ff[g-1][l];
               root_src[g][l] = root_ff[g-1][l];
            end
            side_src[g]  = side_ff[g-1];
            valid_src[g] = valid_ff[g-1];
         end
      end

      // Bring down two radicand bits, try root*4+1, keep one root bit
      always_comb begin
         srem_type rem_sh;
         srem_type trial;
         for (int l = 0; l < LANES; l++) begin
            rem_sh = {rem_src[g][l][SREM_W-3:0], rad_src[g][l][RAD_W-1 -: 2]};
            trial  = srem_type'({root_src[g][l], 2'b01});
            rad_in[g][l] = {rad_src[g][l][RAD_W-3:0], 2'b00};
            if (rem_sh >= trial) begin
               rem_in[g][l]  = rem_sh - trial;
               root_in[g][l] = {root_src[g][l][ROOT_W-2:0], 1'b1};
            end else begin
               rem_in[g][l]  = rem_sh;
               root_in[g][l] = {root_src[g][l][ROOT_W-2:0], 1'b0};
            end
         end
      end

      // Advance valid
      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[g] <= 1'b0;
         end else if (enable) begin
            valid_ff[g] <= valid_src[g];
         end
      end

      // Advance payload
      always_ff @(posedge clock) begin
         if (enable) begin
            side_ff[g] <= side_src[g];
            root_ff[g] <= root_in[g];
         end
      end

      if (g < ROOT_W - 1) begin : g_keep
         always_ff @(posedge clock) begin
            if (enable) begin
               rem_ff[g] <= rem_in[g];
               rad_ff[g] <= rad_in[g];
            end
         end
      end
   end

   assign out_valid = valid_ff[ROOT_W-1];
   assign root      = root_ff[ROOT_W-1];
   assign out_side  = side_ff[ROOT_W-1];

endmodule

`default_nettype wire

// File: sv/quaternion_normalize_unit.sv
// Quaternion normalize unit: Q3.12 quaternion in, Q1.14 unit quaternion out.
// Pipeline from accept to rsp_valid: 2 sum-of-squares stages, 31 divider
// stages (one quotient bit each), 16 square-root stages and the output register.
// Throughput one transaction per cycle; only a held, stalled output blocks the pipe.
// Synchronous reset clears all valid bits; payload registers are not reset.
// Depends on qnorm_pkg, qnorm_sumsq, qnorm_div and qnorm_sqrt.
`default_nettype none

module quaternion_normalize_unit (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire qnorm_pkg::comp_type req_comp_x,
   input  wire qnorm_pkg::comp_type req_comp_y,
   input  wire qnorm_pkg::comp_type req_comp_z,
   input  wire qnorm_pkg::comp_type req_comp_w,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output qnorm_pkg::unit_type      rsp_unit_x,
   output qnorm_pkg::unit_type      rsp_unit_y,
   output qnorm_pkg::unit_type      rsp_unit_z,
   output qnorm_pkg::unit_type      rsp_unit_w,
   output logic                     rsp_zero_length
);
   import qnorm_pkg::*;

   logic        hold;
   logic        advance;

   comp_type    comp [LANES];
   logic        ss_valid;
   sq_type      ss_sq [LANES];
   sum_type     ss_sum;
   side_type    ss_side;
   logic        dv_valid;
   quo_type     dv_quo [LANES];
   side_type    dv_side;
   logic        rt_valid;
   root_type    rt_root [LANES];
   side_type    rt_side;

   logic [ROOT_W:0] round_in [LANES];
   unit_type        unit_in  [LANES];

   logic        rsp_valid_ff;
   unit_type    unit_ff [LANES];
   logic        zero_ff;

   // Hold the pipe only when the output register is full, stalled and a
   // transaction is waiting behind it
   assign hold      = rsp_valid_ff && rsp_stall;
   assign advance   = !hold || !rt_valid;
   assign req_stall = !advance;

   assign comp[LANE_X] = req_comp_x;
   assign comp[LANE_Y] = req_comp_y;
   assign comp[LANE_Z] = req_comp_z;
   assign comp[LANE_W] = req_comp_w;

   qnorm_sumsq u_sumsq (
      .clock     (clock),
      .reset     (reset),
      .enable    (advance),
      .in_valid  (req_valid),
      .comp      (comp),
      .out_valid (ss_valid),
      .sq        (ss_sq),
      .sum       (ss_sum),
      .side      (ss_side)
   );

   qnorm_div u_div (
      .clock     (clock),
      .reset     (reset),
      .enable    (advance),
      .in_valid  (ss_valid),
      .sq        (ss_sq),
      .sum       (ss_sum),
      .in_side   (ss_side),
      .out_valid (dv_valid),
      .quo       (dv_quo),
      .out_side  (dv_side)
   );

   qnorm_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .enable    (advance),
      .in_valid  (dv_valid),
      .quo       (dv_quo),
      .in_side   (dv_side),
      .out_valid (rt_valid),
      .root      (rt_root),
      .out_side  (rt_side)
   );

   // Round: q = (floor(32768*m/len) + 1) / 2, then apply sign or zero
   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         round_in[l] = {1'b0, rt_root[l]} + {{ROOT_W{1'b0}}, 1'b1};
         if (rt_side.zero) begin
            unit_in[l] = '0;
         end else if (rt_side.neg[l]) begin
            unit_in[l] = -unit_type'(round_in[l][ROOT_W:1]);
         end else begin
            unit_in[l] = unit_type'(round_in[l][ROOT_W:1]);
         end
      end
   end

   // Load the output register unless the held result is stalled
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (!hold) begin
         rsp_valid_ff <= rt_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (!hold) begin
         unit_ff <= unit_in;
         zero_ff <= rt_side.zero;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_unit_x      = unit_ff[LANE_X];
   assign rsp_unit_y      = unit_ff[LANE_Y];
   assign rsp_unit_z      = unit_ff[LANE_Z];
   assign rsp_unit_w      = unit_ff[LANE_W];
   assign rsp_zero_length = zero_ff;

   // A zero-length result carries all-zero components
   a_zero_clears : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_zero_length |->
         rsp_unit_x == '0 && rsp_unit_y == '0 && rsp_unit_z == '0 && rsp_unit_w == '0)
      else $error("zero-length result has nonzero components");

   // A unit quaternion never has all components zero
   a_nonzero_unit : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_zero_length |->
         rsp_unit_x != '0 || rsp_unit_y != '0 || rsp_unit_z != '0 || rsp_unit_w != '0)
      else $error("normalized result is all zero");

   // Every component stays within plus or minus one
   a_unit_range : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |->
         rsp_unit_x <= UNIT_ONE && rsp_unit_x >= -UNIT_ONE &&
         rsp_unit_y <= UNIT_ONE && rsp_unit_y >= -UNIT_ONE &&
         rsp_unit_z <= UNIT_ONE && rsp_unit_z >= -UNIT_ONE &&
         rsp_unit_w <= UNIT_ONE && rsp_unit_w >= -UNIT_ONE)
      else $error("normalized component out of range");

   // Input is stalled only behind a held, stalled result
   a_stall_cause : assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled without output backpressure");

endmodule

`default_nettype wire
